[rtl/tbdq_pkg.sv]
// Shared types, constants and format conversion functions for the tensor dequantizer.
package tbdq_pkg;

    localparam int BlockElements = 32;
    localparam int ScaleBytes    = 2;
    localparam int BlockBytes    = BlockElements + ScaleBytes;
    localparam int PosW          = $clog2(BlockBytes);

    typedef enum logic [1:0] {
        TYPE_F32  = 2'd0,
        TYPE_F16  = 2'd1,
        TYPE_Q8_0 = 2'd2,
        TYPE_NONE = 2'd3
    } t_tensor_type;

    localparam logic CFG_TENSOR_TYPE   = 1'b0;
    localparam logic CFG_ELEMENT_COUNT = 1'b1;

    // Index of the highest set bit of a nonzero 10-bit mantissa.
    function automatic logic [3:0] f_msb10(input logic [9:0] m);
        logic [3:0] idx;
        idx = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) idx = 4'(i);
        end
        return idx;
    endfunction

    // Exact IEEE half to single widening; NaNs keep payload, quiet bit set.
    function automatic logic [31:0] f_half_to_single(input logic [15:0] h);
        logic        s;
        logic [4:0]  e;
        logic [9:0]  m;
        logic [3:0]  p;
        logic [9:0]  mn;
        logic [31:0] r;
        s  = h[15];
        e  = h[14:10];
        m  = h[9:0];
        p  = f_msb10(m);
        mn = 10'(m << (4'd10 - p));
        if (e == 5'd0) begin
            if (m == 10'd0) r = {s, 31'd0};
            else r = {s, 8'(8'd103 + {4'd0, p}), mn, 13'd0};
        end else if (e == 5'd31) begin
            if (m == 10'd0) r = {s, 8'hFF, 23'd0};
            else r = {s, 8'hFF, 1'b1, m[8:0], 13'd0};
        end else begin
            r = {s, 8'({3'd0, e} + 8'd112), m, 13'd0};
        end
        return r;
    endfunction

endpackage

[rtl/tbdq_q8_mul.sv]
// Exact fp32 product of a widened fp16 scale and a signed byte.
module tbdq_q8_mul
    import tbdq_pkg::*;
(
    input  logic [15:0] i_scale,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_value
);
    logic [31:0] sbits;
    logic        qs;
    logic [7:0]  qa;
    logic [18:0] prod;
    logic [4:0]  p;
    logic [31:0] norm;
    logic [8:0]  ex;

    always_comb begin
        sbits = f_half_to_single(i_scale);
        qs    = i_byte[7];
        qa    = qs ? 8'(-i_byte) : i_byte;
        // Significand of the widened scale times |q|; fits in 19 bits, so exact.
        prod  = {8'd0, 1'b1, sbits[22:13]} * {11'd0, qa};
        p     = 5'd0;
        for (int i = 0; i < 19; i++) begin
            if (prod[i]) p = 5'(i);
        end
        norm  = 32'({13'd0, prod} << (5'd23 - p));
        ex    = 9'({1'b0, sbits[30:23]} + {4'd0, p} - 9'd10);
        if (i_scale[14:10] == 5'd31) begin
            if (i_scale[9:0] != 10'd0) o_value = sbits;
            else if (qa == 8'd0) o_value = 32'h7FC00000;
            else o_value = {sbits[31] ^ qs, sbits[30:0]};
        end else if (sbits[30:0] == 31'd0 || qa == 8'd0) begin
            o_value = {sbits[31] ^ qs, 31'd0};
        end else begin
            o_value = {sbits[31] ^ qs, ex[7:0], norm[22:0]};
        end
    end
endmodule

[rtl/tensor_block_dequantizer_unit.sv]
// Top level of the tensor dequantizer: byte stream in, fp32 values out.
//  channel | direction | handshake            | payload
//  input   | in        | i_valid / o_stall    | i_data_byte[7:0]
//  output  | out       | o_valid / i_stall    | o_value_bits[31:0], o_last_element
//  config  | in        | i_cfg_we             | i_cfg_index, i_cfg_data[31:0]
// One byte is accepted per cycle while o_stall is low; a result appears in the
// cycle after the byte that completes it, from the single result register.
// Reset (synchronous, active low) clears all counters and sets the configuration to f32 with one element.
// A stalled output holds; input is stalled only while a held result is
// not taken, so output stalls propagate back in the same cycle.
module tensor_block_dequantizer_unit
    import tbdq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_value_bits,
    output logic        o_last_element,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    t_tensor_type r_type;
    logic [31:0]  r_count, r_done;
    logic [PosW-1:0] r_pos;
    logic [15:0]  r_scale;
    logic [23:0]  r_gath;
    logic         r_ovalid;
    logic [31:0]  r_value;
    logic         r_last;

    logic         acc, emit, last;
    logic [31:0]  value, q8_value;
    logic [PosW-1:0] n_pos;
    logic [31:0]  n_done;
    logic [23:0]  n_gath;
    logic [15:0]  n_scale;

    tbdq_q8_mul u_mul (.i_scale(r_scale), .i_byte(i_data_byte), .o_value(q8_value));

    assign o_stall = r_ovalid & i_stall;
    assign acc     = i_valid & ~o_stall;
    assign last    = (r_done == r_count - 32'd1);

    always_comb begin
        emit  = 1'b0;
        value = 32'd0;
        n_pos = r_pos;
        unique case (r_type)
            TYPE_F32: begin
                if (r_pos == PosW'(3)) begin
                    emit = 1'b1; value = {i_data_byte, r_gath}; n_pos = '0;
                end else n_pos = r_pos + PosW'(1);
            end
            TYPE_F16: begin
                if (r_pos != '0) begin
                    emit = 1'b1; value = f_half_to_single({i_data_byte, r_gath[7:0]});
                    n_pos = '0;
                end else n_pos = PosW'(1);
            end
            TYPE_Q8_0: begin
                if (r_pos >= PosW'(ScaleBytes)) begin
                    emit = 1'b1; value = q8_value;
                end
                n_pos = (r_pos == PosW'(BlockBytes - 1)) ? '0 : r_pos + PosW'(1);
            end
            default: ;
        endcase
    end

    // Next stream state for an accepted item; the final element restarts the stream.
    always_comb begin
        n_done  = r_done;
        n_gath  = r_gath;
        n_scale = r_scale;
        if (r_type == TYPE_F32 && !emit) n_gath[8*r_pos[1:0] +: 8] = i_data_byte;
        if (r_type == TYPE_F16 && !emit) n_gath[7:0] = i_data_byte;
        if (r_type == TYPE_Q8_0 && r_pos == '0) n_scale[7:0] = i_data_byte;
        if (r_type == TYPE_Q8_0 && r_pos == PosW'(1)) n_scale[15:8] = i_data_byte;
        if (emit) begin
            n_done = r_done + 32'd1;
            if (r_type != TYPE_Q8_0) n_gath = '0;
            if (last) begin
                n_done  = '0;
                n_gath  = '0;
                n_scale = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type <= TYPE_F32; r_count <= 32'd1; r_done <= '0; r_pos <= '0;
            r_scale <= '0; r_gath <= '0; r_ovalid <= 1'b0;
        end else begin
            if (acc && emit && !i_cfg_we) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_TENSOR_TYPE) r_type <= t_tensor_type'(i_cfg_data[1:0]);
                else r_count <= i_cfg_data;
                r_done <= '0; r_pos <= '0; r_scale <= '0; r_gath <= '0;
            end else if (acc) begin
                r_pos   <= (emit && last) ? '0 : n_pos;
                r_done  <= n_done;
                r_gath  <= n_gath;
                r_scale <= n_scale;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && emit && !i_cfg_we) begin
            r_value <= value;
            r_last  <= last;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_value_bits   = r_value;
    assign o_last_element = r_last;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && i_stall |=> r_ovalid && $stable(r_value))
        else $error("held result changed");
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < PosW'(BlockBytes))
        else $error("byte position out of range");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && emit && last && !i_cfg_we |=> r_done == '0 && r_pos == '0)
        else $error("counters not cleared after last");
endmodule

[tb/tensor_block_dequantizer_unit_chk.sv]
// Checker for the tensor dequantizer: predicts fp32 results from the byte stream and compares.
module tensor_block_dequantizer_unit_chk
    import tbdq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_value_bits,
    input  logic        i_last_element,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_values_seen
);

    typedef struct packed {
        logic [31:0] bits;
        logic        last;
    } t_value;

    t_value       values_due[$];
    t_tensor_type fmt;
    logic [31:0]  elem_total;
    int           byte_pos;
    logic [15:0]  scale_reg;
    logic [31:0]  elems_done;
    logic [23:0]  gathered;

    assign o_pending = values_due.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h (result %0d)", what, got, want,
            o_values_seen);
        o_mismatches++;
    endtask

    // Builds an fp32 from sign and a nonzero integer magnitude times 2^pow2.
    function automatic logic [31:0] pack_single(input logic s, input logic [17:0] mag,
                                                input int pow2);
        int          k;
        logic [40:0] wide;
        k = 0;
        for (int i = 0; i < 18; i++) if (mag[i]) k = i;
        wide = 41'(mag) << (23 - k);
        return {s, 8'(k + pow2 + 127), wide[22:0]};
    endfunction

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [4:0] e;
        e = h[14:10];
        if (e == 5'd31)
            return (h[9:0] == 0) ? {h[15], 8'hFF, 23'd0} : {h[15], 8'hFF, 1'b1, h[8:0], 13'd0};
        if (e == 0) begin
            if (h[9:0] == 0) return {h[15], 31'd0};
            return pack_single(h[15], 18'(h[9:0]), -24);
        end
        return pack_single(h[15], 18'({1'b1, h[9:0]}), int'(e) - 25);
    endfunction

    // Exact product of an fp16 scale and a signed byte.
    function automatic logic [31:0] scale_product(input logic [15:0] h, input logic [7:0] q);
        logic [4:0]  e;
        logic        neg;
        logic [7:0]  qmag;
        logic [17:0] mag;
        int          pow2;
        e    = h[14:10];
        neg  = q[7];
        qmag = neg ? 8'(-q) : q;
        if (e == 5'd31) begin
            if (h[9:0] != 0) return widen_half(h);
            if (q == 0) return 32'h7FC0_0000;
            return {h[15] ^ neg, 8'hFF, 23'd0};
        end
        if (e == 0) begin
            mag  = 18'(h[9:0]) * 18'(qmag);
            pow2 = -24;
        end else begin
            mag  = 18'({1'b1, h[9:0]}) * 18'(qmag);
            pow2 = int'(e) - 25;
        end
        if (mag == 0) return {h[15] ^ neg, 31'd0};
        return pack_single(h[15] ^ neg, mag, pow2);
    endfunction

    task automatic restart_stream();
        byte_pos   = 0;
        scale_reg  = '0;
        elems_done = '0;
        gathered   = '0;
    endtask

    task automatic predict_byte(input logic [7:0] b);
        logic [31:0] v;
        logic        fin;
        t_value      item;
        case (fmt)
            TYPE_F32: begin
                if (byte_pos < 3) begin
                    gathered[8*byte_pos +: 8] = b;
                    byte_pos++;
                    return;
                end
                v = {b, gathered};
                byte_pos = 0;
                gathered = '0;
            end
            TYPE_F16: begin
                if (byte_pos == 0) begin
                    gathered = 24'(b);
                    byte_pos = 1;
                    return;
                end
                v = widen_half({b, gathered[7:0]});
                byte_pos = 0;
                gathered = '0;
            end
            TYPE_Q8_0: begin
                if (byte_pos < 2) begin
                    scale_reg[8*byte_pos +: 8] = b;
                    byte_pos++;
                    return;
                end
                v = scale_product(scale_reg, b);
                byte_pos++;
                if (byte_pos >= BlockBytes) byte_pos = 0;
            end
            default: return;
        endcase
        fin = (elems_done == elem_total - 32'd1);
        elems_done++;
        if (fin) restart_stream();
        item.bits = v;
        item.last = fin;
        values_due.insert(values_due.size(), item);
    endtask

    always @(posedge i_clk) begin
        t_value want;
        if (!i_rst_n) begin
            fmt         = TYPE_F32;
            elem_total  = 32'd1;
            restart_stream();
            values_due.delete();
            o_mismatches  = 0;
            o_values_seen = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_TENSOR_TYPE) fmt = t_tensor_type'(i_cfg_data[1:0]);
                else elem_total = i_cfg_data;
                restart_stream();
            end
            if (i_out_valid && !i_out_stall) begin
                if (values_due.size() == 0) begin
                    report("unexpected value", i_value_bits, 32'd0);
                end else begin
                    want = values_due.pop_front();
                    if (i_value_bits !== want.bits) report("value_bits", i_value_bits, want.bits);
                    if (i_last_element !== want.last)
                        report("last_element", 32'(i_last_element), 32'(want.last));
                end
                o_values_seen++;
            end
            if (i_valid && !i_in_stall) predict_byte(i_data_byte);
        end
    end

endmodule

[tb/tensor_block_dequantizer_unit_tb.sv]
// Testbench top for the tensor dequantizer: stimulus, stalls and the final verdict.
module tensor_block_dequantizer_unit_tb;
    import tbdq_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_value_bits;
    logic        o_last_element;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = '0;

    int mismatches, pending, values_seen;
    int missing = 0;
    int cycles = 0;
    int bytes_sent = 0;
    int stall_left = 0;
    bit stall_quiet = 1'b0;
    bit gaps_quiet = 1'b0;

    always #1 i_clk = ~i_clk;

    tensor_block_dequantizer_unit i_dut (.*);

    tensor_block_dequantizer_unit_chk i_chk (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_data_byte,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_value_bits(o_value_bits),
        .i_last_element(o_last_element), .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_mismatches(mismatches), .o_pending(pending), .o_values_seen(values_seen)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(99) < 8) return $urandom_range(40, 10);
        if ($urandom_range(99) < 35) return $urandom_range(3, 1);
        return 0;
    endfunction

    // Output back-pressure: short bursts mostly, an occasional long one.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (!stall_quiet && $urandom_range(3) == 0) begin
            stall_left <= pick_gap();
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = gaps_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
    endtask

    task automatic push_half(input logic [15:0] h);
        push_byte(h[7:0]);
        push_byte(h[15:8]);
    endtask

    // Registers change only once the block has drained; partial elements leave no result.
    task automatic write_reg(input logic idx, input logic [31:0] val);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_mode(input t_tensor_type t, input logic [31:0] n);
        write_reg(CFG_TENSOR_TYPE, 32'(t));
        write_reg(CFG_ELEMENT_COUNT, n);
    endtask

    initial begin
        t_tensor_type plan_t[10] = '{TYPE_F32, TYPE_F16, TYPE_Q8_0, TYPE_Q8_0, TYPE_F32,
                                     TYPE_Q8_0, TYPE_NONE, TYPE_F16, TYPE_Q8_0, TYPE_F32};
        logic [31:0]  plan_n[10] = '{32'd1, 32'd5, 32'd40, 32'd32, 32'hFFFF_FFFF,
                                     32'd1, 32'd3, 32'd0, 32'hFFFF_FFFF, 32'd7};
        logic [15:0]  halves[10] = '{16'h0000, 16'h8000, 16'h0001, 16'h83FF, 16'h3C00,
                                     16'h7BFF, 16'h7C00, 16'hFC00, 16'h7E01, 16'hFFFF};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: half-float special values, then Q8_0 scale corner cases, then one f32 value.
        set_mode(TYPE_F16, 32'd10);
        foreach (halves[k]) push_half(halves[k]);
        set_mode(TYPE_Q8_0, 32'd3);
        push_half(16'h7C00);
        push_byte(8'h00);
        push_byte(8'h80);
        push_byte(8'h7F);
        set_mode(TYPE_Q8_0, 32'd2);
        push_half(16'hFE01);
        push_byte(8'h05);
        push_byte(8'h00);
        set_mode(TYPE_F32, 32'd1);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(8'h7F);

        // Random phases; a few run without idling on either side.
        foreach (plan_t[p]) begin
            set_mode(plan_t[p], plan_n[p]);
            gaps_quiet = (p % 4 == 3);
            stall_quiet = (p % 4 == 3);
            repeat ((plan_t[p] == TYPE_NONE) ? 12 : 85) begin
                if (plan_t[p] == TYPE_Q8_0 && $urandom_range(4) == 0)
                    push_byte(8'($urandom_range(255)) & 8'h3C);
                else
                    push_byte(8'($urandom_range(255)));
            end
        end
        gaps_quiet = 1'b0;
        stall_quiet = 1'b0;

        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (pending != 0) begin
            $display("%0d expected values never arrived", pending);
            missing++;
        end
        $display("Sent %0d bytes over f32, f16, Q8_0 and unused formats; checked %0d values.",
            bytes_sent, values_seen);
        if (mismatches == 0 && missing == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
